// File: rtl/itq_pkg.sv
`default_nettype none
package itq_pkg;
   localparam int SCALE_TOP = 30;
   localparam int SQ_BITS = 64;
   localparam int HQ_STEPS = 60;
endpackage
`default_nettype wire

// File: rtl/itq_sqrt_cell.sv
`default_nettype none
module itq_sqrt_cell
   import itq_pkg::*;
#(
   parameter int W = 64
) (
   input  wire logic [W-1:0] v_in_val,
   input  wire logic [W-1:0] r_in_val,
   input  wire logic [W-1:0] bit_val,
   output logic      [W-1:0] v_out_val,
   output logic      [W-1:0] r_out_val
);
   always_comb begin
      if (v_in_val >= r_in_val + bit_val) begin
         v_out_val = v_in_val - (r_in_val + bit_val);
         r_out_val = (r_in_val >> 1) + bit_val;
      end else begin
         v_out_val = v_in_val;
         r_out_val = r_in_val >> 1;
      end
   end
endmodule
`default_nettype wire

// File: rtl/itq_div_cell.sv
`default_nettype none
module itq_div_cell
   import itq_pkg::*;
(
   input  wire logic [63:0] rem_in_val,
   input  wire logic [63:0] q_in_val,
   input  wire logic [63:0] den_val,
   output logic      [63:0] rem_out_val,
   output logic      [63:0] q_out_val
);
   logic [64:0] sh;
   always_comb begin
      sh = {rem_in_val, 1'b0};
      if (sh >= {1'b0, den_val}) begin
         rem_out_val = 64'(sh - {1'b0, den_val});
         q_out_val = {q_in_val[62:0], 1'b1};
      end else begin
         rem_out_val = sh[63:0];
         q_out_val = {q_in_val[62:0], 1'b0};
      end
   end
endmodule
`default_nettype wire

// File: rtl/imu_tilt_quaternion_frame_flip_unit.sv
// channel | ports                         | direction
// req     | req_valid/req_stall, 6 axes   | in
// rsp     | rsp_valid/rsp_stall, 10 fields| out
// Pipelined chain of root and divide cells, one register stage per cell.
// One transfer per cycle while req_stall is low; each result passes these register
// stages in order (scale, square, 32 root, numerator, 60 divide, 32 root, product, round).
// Reset clears the stage valids only. A stalled result freezes every stage;
// req_stall follows rsp_stall only while a result is held.
`default_nettype none
module imu_tilt_quaternion_frame_flip_unit
   import itq_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int QUAT_FRAC_BITS = 14
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  wire logic signed [SAMPLE_BITS-1:0] req_gyro_x,
   input  wire logic signed [SAMPLE_BITS-1:0] req_gyro_y,
   input  wire logic signed [SAMPLE_BITS-1:0] req_gyro_z,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_flipped_accel_x,
   output logic signed [SAMPLE_BITS-1:0] rsp_flipped_accel_y,
   output logic signed [SAMPLE_BITS-1:0] rsp_flipped_accel_z,
   output logic signed [SAMPLE_BITS-1:0] rsp_flipped_gyro_x,
   output logic signed [SAMPLE_BITS-1:0] rsp_flipped_gyro_y,
   output logic signed [SAMPLE_BITS-1:0] rsp_flipped_gyro_z,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z
);
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam int NS = SQ_BITS / 2;
   localparam int SH = 60 - QUAT_FRAC_BITS;
   localparam int NUMS = 2 + NS;
   localparam int PRS = NUMS + 1 + HQ_STEPS + NS;
   localparam int LAT = PRS + 2;
   localparam logic [31:0] ONE_Q30 = 32'd1 << SCALE_TOP;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] fax, fay, faz, fgx, fgy, fgz;
      logic srneg, spneg, azneg, rzero, pzero;
      logic [31:0] m2z;
   } side_type;

   function automatic logic signed [SAMPLE_BITS-1:0] neg_sat(
      input logic signed [SAMPLE_BITS-1:0] v);
      neg_sat = (v == SMIN) ? SMAX : -v;
   endfunction

   function automatic logic [31:0] amag(input logic signed [SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS-1:0] u;
      u = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
      amag = 32'(u);
   endfunction

   function automatic logic [5:0] lz(input logic [31:0] m);
      logic [5:0] s;
      s = 6'd0;
      for (int i = 0; i <= 30; i++) begin
         if (m[i]) s = 6'(30 - i);
      end
      lz = m[31] ? 6'd0 : s;
   endfunction

   function automatic logic [15:0] qout(input logic [63:0] m, input logic neg);
      logic [63:0] r;
      logic signed [17:0] v;
      r = (m + (64'd1 << (SH - 1))) >> SH;
      if (r > 64'd32768) r = 64'd32768;
      v = neg ? -18'(r[16:0]) : 18'(r[16:0]);
      if (v > 18'sd32767) v = 18'sd32767;
      qout = v[15:0];
   endfunction

   logic [31:0] max, may, maz, m2y, m2z, m3x, m3y, m3z, mx2, mx3;
   logic [5:0] s2, s3;
   side_type side_in;
   side_type side_ff [LAT];
   logic vld_ff [LAT];
   logic [31:0] m2y_ff, m3x_ff, m3y_ff, m3z_ff;
   logic [63:0] sq_ff [3];
   logic [63:0] sv_prev [3][NS];
   logic [63:0] sr_prev [3][NS];
   logic [63:0] sv_in [3][NS];
   logic [63:0] sr_in [3][NS];
   logic [63:0] sv_ff [3][NS];
   logic [63:0] sr_ff [3][NS];
   logic [63:0] rr, nn, pp;
   logic [63:0] num_in [4];
   logic [63:0] num_ff [4];
   logic [63:0] den_in [2];
   logic [63:0] den_ff [2];
   logic [63:0] dn_prev [2][HQ_STEPS];
   logic [63:0] dn_ff [2][HQ_STEPS];
   logic [63:0] dr_prev [4][HQ_STEPS];
   logic [63:0] dq_prev [4][HQ_STEPS];
   logic [63:0] dr_in [4][HQ_STEPS];
   logic [63:0] dq_in [4][HQ_STEPS];
   logic [63:0] dr_ff [4][HQ_STEPS];
   logic [63:0] dq_ff [4][HQ_STEPS];
   logic [63:0] tv_prev [4][NS];
   logic [63:0] tr_prev [4][NS];
   logic [63:0] tv_in [4][NS];
   logic [63:0] tr_in [4][NS];
   logic [63:0] tv_ff [4][NS];
   logic [63:0] tr_ff [4][NS];
   logic [31:0] cr, srl, cp, sp;
   logic [63:0] prod_ff [4];
   logic [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic adv, take;

   always_comb begin
      max = amag(req_accel_x);
      may = amag(req_accel_y);
      maz = amag(req_accel_z);
      mx2 = (may > maz) ? may : maz;
      mx3 = (max > mx2) ? max : mx2;
      s2 = (mx2 == '0) ? 6'd0 : lz(mx2);
      s3 = (mx3 == '0) ? 6'd0 : lz(mx3);
      m2y = may << s2;
      m2z = maz << s2;
      m3x = max << s3;
      m3y = may << s3;
      m3z = maz << s3;
      side_in.fax = req_accel_x;
      side_in.fay = neg_sat(req_accel_y);
      side_in.faz = neg_sat(req_accel_z);
      side_in.fgx = req_gyro_x;
      side_in.fgy = neg_sat(req_gyro_y);
      side_in.fgz = neg_sat(req_gyro_z);
      side_in.srneg = req_accel_y[SAMPLE_BITS-1];
      side_in.spneg = req_accel_x[SAMPLE_BITS-1];
      side_in.azneg = req_accel_z[SAMPLE_BITS-1];
      side_in.rzero = (mx2 == '0);
      side_in.pzero = (mx3 == '0);
      side_in.m2z = m2z;
   end

   always_comb begin
      rr = sr_ff[0][NS-1];
      nn = sr_ff[1][NS-1];
      pp = sr_ff[2][NS-1];
      for (int k = 0; k < 3; k++) begin
         sv_prev[k][0] = sq_ff[k];
         sr_prev[k][0] = '0;
         for (int i = 1; i < NS; i++) begin
            sv_prev[k][i] = sv_ff[k][i-1];
            sr_prev[k][i] = sr_ff[k][i-1];
         end
      end
      if (side_ff[NUMS-1].azneg) begin
         num_in[0] = rr - 64'(side_ff[NUMS-1].m2z);
         num_in[1] = rr + 64'(side_ff[NUMS-1].m2z);
      end else begin
         num_in[0] = rr + 64'(side_ff[NUMS-1].m2z);
         num_in[1] = rr - 64'(side_ff[NUMS-1].m2z);
      end
      num_in[2] = nn + pp;
      num_in[3] = nn - pp;
      den_in[0] = (rr == '0) ? 64'd1 : rr << 1;
      den_in[1] = (nn == '0) ? 64'd1 : nn << 1;
      for (int c = 0; c < 2; c++) begin
         dn_prev[c][0] = den_ff[c];
         for (int j = 1; j < HQ_STEPS; j++) dn_prev[c][j] = dn_ff[c][j-1];
      end
      for (int k = 0; k < 4; k++) begin
         if (num_ff[k] >= den_ff[k >> 1]) begin
            dr_prev[k][0] = num_ff[k] - den_ff[k >> 1];
            dq_prev[k][0] = 64'd1;
         end else begin
            dr_prev[k][0] = num_ff[k];
            dq_prev[k][0] = 64'd0;
         end
         for (int j = 1; j < HQ_STEPS; j++) begin
            dr_prev[k][j] = dr_ff[k][j-1];
            dq_prev[k][j] = dq_ff[k][j-1];
         end
         tv_prev[k][0] = dq_ff[k][HQ_STEPS-1];
         tr_prev[k][0] = '0;
         for (int i = 1; i < NS; i++) begin
            tv_prev[k][i] = tv_ff[k][i-1];
            tr_prev[k][i] = tr_ff[k][i-1];
         end
      end
      if (side_ff[PRS-1].rzero) begin
         cr = ONE_Q30;
         srl = '0;
      end else begin
         cr = tr_ff[0][NS-1][31:0];
         srl = tr_ff[1][NS-1][31:0];
      end
      if (side_ff[PRS-1].pzero) begin
         cp = ONE_Q30;
         sp = '0;
      end else begin
         cp = tr_ff[2][NS-1][31:0];
         sp = tr_ff[3][NS-1][31:0];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_root
      for (genvar i = 0; i < NS; i++) begin : g_s
         itq_sqrt_cell #(.W(64)) u_s (
            .v_in_val(sv_prev[k][i]), .r_in_val(sr_prev[k][i]),
            .bit_val(64'd1 << (62 - 2 * i)),
            .v_out_val(sv_in[k][i]), .r_out_val(sr_in[k][i]));
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_ch
      for (genvar j = 0; j < HQ_STEPS; j++) begin : g_d
         itq_div_cell u_d (
            .rem_in_val(dr_prev[k][j]), .q_in_val(dq_prev[k][j]),
            .den_val(dn_prev[k / 2][j]),
            .rem_out_val(dr_in[k][j]), .q_out_val(dq_in[k][j]));
      end
      for (genvar i = 0; i < NS; i++) begin : g_t
         itq_sqrt_cell #(.W(64)) u_t (
            .v_in_val(tv_prev[k][i]), .r_in_val(tr_prev[k][i]),
            .bit_val(64'd1 << (62 - 2 * i)),
            .v_out_val(tv_in[k][i]), .r_out_val(tr_in[k][i]));
      end
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign req_stall = rsp_valid && rsp_stall;
   assign adv = !req_stall;
   assign take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LAT; i++) side_ff[i] <= side_ff[i-1];
         m2y_ff <= m2y;
         m3x_ff <= m3x;
         m3y_ff <= m3y;
         m3z_ff <= m3z;
         sq_ff[0] <= m2y_ff * m2y_ff + side_ff[0].m2z * side_ff[0].m2z;
         sq_ff[1] <= m3x_ff * m3x_ff + m3y_ff * m3y_ff + m3z_ff * m3z_ff;
         sq_ff[2] <= m3y_ff * m3y_ff + m3z_ff * m3z_ff;
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < NS; i++) begin
               sv_ff[k][i] <= sv_in[k][i];
               sr_ff[k][i] <= sr_in[k][i];
            end
         end
         for (int c = 0; c < 2; c++) begin
            den_ff[c] <= den_in[c];
            for (int j = 0; j < HQ_STEPS; j++) dn_ff[c][j] <= dn_prev[c][j];
         end
         for (int k = 0; k < 4; k++) begin
            num_ff[k] <= num_in[k];
            for (int j = 0; j < HQ_STEPS; j++) begin
               dr_ff[k][j] <= dr_in[k][j];
               dq_ff[k][j] <= dq_in[k][j];
            end
            for (int i = 0; i < NS; i++) begin
               tv_ff[k][i] <= tv_in[k][i];
               tr_ff[k][i] <= tr_in[k][i];
            end
         end
         prod_ff[0] <= cr * cp;
         prod_ff[1] <= srl * cp;
         prod_ff[2] <= cr * sp;
         prod_ff[3] <= srl * sp;
         qw_ff <= qout(prod_ff[0], 1'b0);
         qx_ff <= qout(prod_ff[1], side_ff[PRS].srneg);
         qy_ff <= qout(prod_ff[2], side_ff[PRS].spneg);
         qz_ff <= qout(prod_ff[3], !(side_ff[PRS].srneg != side_ff[PRS].spneg));
      end
   end

   assign rsp_flipped_accel_x = side_ff[LAT-1].fax;
   assign rsp_flipped_accel_y = side_ff[LAT-1].fay;
   assign rsp_flipped_accel_z = side_ff[LAT-1].faz;
   assign rsp_flipped_gyro_x = side_ff[LAT-1].fgx;
   assign rsp_flipped_gyro_y = side_ff[LAT-1].fgy;
   assign rsp_flipped_gyro_z = side_ff[LAT-1].fgz;
   assign rsp_quat_w = qw_ff;
   assign rsp_quat_x = qx_ff;
   assign rsp_quat_y = qy_ff;
   assign rsp_quat_z = qz_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_w))
      else $error("result lost under stall");
   a_take: assert property (@(posedge clock) disable iff (reset)
      take |=> vld_ff[0])
      else $error("transfer not captured");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result held");
endmodule
`default_nettype wire
